// ===== design/arld_pkg.sv =====
// shared types and constants for the audio ring drain block
// no dependencies; design files refer to this package by scoped names, the bench imports it
`default_nettype none

package arld_pkg;

   localparam int RING_FRAMES = 1024;
   localparam int RING_AW     = $clog2(RING_FRAMES);
   localparam int PERIOD_MAX  = 64;
   localparam int ENTRY_W     = 48;
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

   localparam logic [16:0] STALL_MAX = 17'h1FFFF;

   typedef enum logic [1:0] {
      REQ_PUSH    = 2'd0,
      REQ_STATUS  = 2'd1,
      REQ_CONSUME = 2'd2,
      REQ_NONE    = 2'd3
   } arld_req_code_type;

   typedef enum logic [1:0] {
      CSR_GRANTED_SESSION = 2'd0,
      CSR_STALL_LIMIT     = 2'd1,
      CSR_SAMPLE_FORMAT   = 2'd2,
      CSR_OUT_CHANNELS    = 2'd3
   } arld_csr_code_type;

   typedef enum logic [1:0] {
      FMT_INT16 = 2'd0,
      FMT_INT24 = 2'd1,
      FMT_INT32 = 2'd2,
      FMT_NONE  = 2'd3
   } arld_fmt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_GATE,
      ST_DRAIN
   } arld_state_type;

   typedef struct packed {
      logic       from_ring;
      logic [5:0] frame_index;
      logic       last;
   } arld_meta_type;

   typedef struct packed {
      logic signed [31:0] ch0_word;
      logic signed [31:0] ch1_word;
      logic [5:0]         frame_index;
      logic               from_ring;
      logic               last;
   } arld_rsp_type;

endpackage

`default_nettype wire

// ===== design/arld_ifs.sv =====
// channel interfaces: request, response and register write
// depends on arld_pkg for nothing but is compiled after it
`default_nettype none

interface arld_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic signed [23:0] left_sample;
   logic signed [23:0] right_sample;
   logic [31:0]        session_id;
   logic [31:0]        heartbeat_value;
   logic [6:0]         frame_count;

   modport source (output valid, req_type, left_sample, right_sample, session_id,
                   heartbeat_value, frame_count, input ready);
   modport sink (input valid, req_type, left_sample, right_sample, session_id,
                 heartbeat_value, frame_count, output ready);
endinterface

interface arld_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] ch0_word;
   logic signed [31:0] ch1_word;
   logic [5:0]         frame_index;
   logic               from_ring;
   logic               last;

   modport source (output valid, ch0_word, ch1_word, frame_index, from_ring, last,
                   input ready);
   modport sink (input valid, ch0_word, ch1_word, frame_index, from_ring, last,
                 output ready);
endinterface

interface arld_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  addr;
   logic [31:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== design/arld_ring_ram.sv =====
// generic single-write, single-read synchronous ram, registered read data
// no package dependency
`default_nettype none

module arld_ring_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/arld_scale.sv =====
// three-stage sample scaler: magnitude, multiply by 2^b-1, shift and re-sign
// depends on arld_pkg for the format codes and the meta/response structs
`default_nettype none

module arld_scale (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire arld_pkg::arld_meta_type in_meta,
   input  wire logic [47:0]            in_entry,
   input  wire logic [1:0]             sample_format,
   input  wire logic                   mono,
   output logic                        out_valid,
   output arld_pkg::arld_rsp_type      out_rsp
);

   // mag * (2^b - 1) as a shift and subtract
   function automatic logic [55:0] scale_prod(input logic [24:0] mag, input logic [1:0] fmt);
      logic [55:0] m;
      logic [55:0] p;
      m = {31'd0, mag};
      case (fmt)
         arld_pkg::FMT_INT16: p = (m << 15) - m;
         arld_pkg::FMT_INT24: p = (m << 23) - m;
         arld_pkg::FMT_INT32: p = (m << 31) - m;
         default:             p = '0;
      endcase
      return p;
   endfunction

   // stage 1: channel numerators and magnitudes
   logic                    s1_valid_ff;
   arld_pkg::arld_meta_type s1_meta_ff;
   logic [24:0]             s1_mag_a_ff, s1_mag_b_ff;
   logic                    s1_neg_a_ff, s1_neg_b_ff;
   logic signed [24:0]      num_a, num_b;

   // stage 2: products
   logic                    s2_valid_ff;
   arld_pkg::arld_meta_type s2_meta_ff;
   logic [55:0]             s2_prod_a_ff, s2_prod_b_ff;
   logic                    s2_neg_a_ff, s2_neg_b_ff;

   // stage 3: result
   logic                    s3_valid_ff;
   arld_pkg::arld_rsp_type  s3_rsp_ff, s3_rsp_in;
   logic [31:0]             q_a, q_b;

   always_comb begin
      num_b = 25'(signed'(in_entry[47:24]));
      if (mono) begin
         num_a = 25'(signed'(in_entry[23:0])) + num_b;
      end else begin
         num_a = 25'(signed'(in_entry[23:0]));
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff  <= in_meta;
      s1_neg_a_ff <= num_a[24];
      s1_neg_b_ff <= num_b[24];
      s1_mag_a_ff <= num_a[24] ? 25'(-num_a) : 25'(num_a);
      s1_mag_b_ff <= num_b[24] ? 25'(-num_b) : 25'(num_b);

      s2_meta_ff   <= s1_meta_ff;
      s2_neg_a_ff  <= s1_neg_a_ff;
      s2_neg_b_ff  <= s1_neg_b_ff;
      s2_prod_a_ff <= scale_prod(s1_mag_a_ff, sample_format);
      s2_prod_b_ff <= scale_prod(s1_mag_b_ff, sample_format);

      s3_rsp_ff <= s3_rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_comb begin
      // mono sum carries one more fraction bit
      if (mono) begin
         q_a = s2_prod_a_ff[55:24];
      end else begin
         q_a = s2_prod_a_ff[54:23];
      end
      q_b = s2_prod_b_ff[54:23];

      s3_rsp_in.frame_index = s2_meta_ff.frame_index;
      s3_rsp_in.from_ring   = s2_meta_ff.from_ring;
      s3_rsp_in.last        = s2_meta_ff.last;
      s3_rsp_in.ch0_word    = '0;
      s3_rsp_in.ch1_word    = '0;
      if (s2_meta_ff.from_ring) begin
         s3_rsp_in.ch0_word = s2_neg_a_ff ? -q_a : q_a;
         if (!mono) begin
            s3_rsp_in.ch1_word = s2_neg_b_ff ? -q_b : q_b;
         end
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_rsp   = s3_rsp_ff;

endmodule

`default_nettype wire

// ===== design/arld_out_fifo.sv =====
// small response queue between the scaler and the response channel
// depends on arld_pkg for the depth constants and the response struct
`default_nettype none

module arld_out_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire arld_pkg::arld_rsp_type push_data,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output arld_pkg::arld_rsp_type      pop_data
);

   arld_pkg::arld_rsp_type        slot [arld_pkg::FIFO_DEPTH];
   logic [arld_pkg::FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [arld_pkg::FIFO_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [arld_pkg::FIFO_CW-1:0]  count_ff, count_in;
   logic                          pop;

   assign pop       = pop_valid && pop_ready;
   assign pop_valid = (count_ff != '0);
   assign pop_data  = slot[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/audio_ring_drain_with_liveness_top.sv =====
// Stereo sample ring with a gated, liveness-checked reader.
// req_ch carries push, status and consume items, one transfer at a time; a push writes
// one ring slot and a status item updates the producer session and heartbeat. A consume
// first passes a gate state for the grant and heartbeat check and the lapped-reader
// fixup, then issues one frame per cycle while credit remains from the 1024-entry ring
// memory (one read port); req_ch is not ready again until the consume is done.
// Each frame passes the ram read and a three-stage scaler and lands in an 8-entry
// response queue, from which it is handed to rsp_ch.
// Frame issue is credit based: with rsp_ch stalled, at most 8 frames are in flight or
// queued, then issue pauses until the receiver takes a transfer. Nothing is dropped.
// Registers arrive on csr_ch (always ready) and are meant to change only while idle.
// Reset clears indices, producer and liveness state and loads the register defaults
// (no grant, stall limit 8, int16, stereo). The ring contents are undefined after reset
// and need no clearing pass. Depends on arld_pkg, the channel interfaces, arld_ring_ram,
// arld_scale and arld_out_fifo.
`default_nettype none

module audio_ring_drain_with_liveness_top (
   input wire logic  clock,
   input wire logic  reset,
   arld_req_if.sink  req_ch,
   arld_rsp_if.source rsp_ch,
   arld_csr_if.sink  csr_ch
);

   // registers
   logic [31:0] granted_session_ff;
   logic [15:0] stall_limit_ff;
   logic [1:0]  sample_format_ff;
   logic [3:0]  out_channels_ff;
   logic        mono;

   // block state
   arld_pkg::arld_state_type state_ff, state_in;
   logic [31:0] write_index_ff, write_index_in;
   logic [31:0] read_index_ff, read_index_in;
   logic [31:0] prod_session_ff, prod_session_in;
   logic [31:0] prod_heartbeat_ff, prod_heartbeat_in;
   logic [31:0] seen_grant_ff, seen_grant_in;
   logic [31:0] last_heartbeat_ff, last_heartbeat_in;
   logic [16:0] stall_count_ff, stall_count_in;

   // period control
   logic [6:0]                    n_ff, n_in;
   logic [6:0]                    give_ff, give_in;
   logic [6:0]                    frame_ff, frame_in;
   logic [arld_pkg::RING_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [arld_pkg::FIFO_CW-1:0]  credit_ff, credit_in;

   // control outputs
   logic req_ready;
   logic gate_cycle;
   logic issue;
   logic req_fire;
   logic last_frame;

   // gate evaluation
   logic        live;
   logic [16:0] stall_inc;
   logic [31:0] avail, avail_c, r_start;
   logic        lapped;

   // datapath
   logic                    ram_we;
   logic [47:0]             ram_q;
   arld_pkg::arld_meta_type issue_meta, meta1_ff;
   logic                    valid1_ff;
   logic                    sc_valid;
   arld_pkg::arld_rsp_type  sc_rsp, q_rsp;
   logic                    rsp_pop;

   assign csr_ch.ready = 1'b1;
   assign mono         = (out_channels_ff == 4'd1);
   assign req_ch.ready = req_ready;
   assign req_fire     = req_ch.valid && req_ready;
   assign rsp_pop      = rsp_ch.valid && rsp_ch.ready;
   assign last_frame   = ((frame_ff + 7'd1) == n_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         granted_session_ff <= '0;
         stall_limit_ff     <= 16'd8;
         sample_format_ff   <= arld_pkg::FMT_INT16;
         out_channels_ff    <= 4'd2;
      end else if (csr_ch.valid) begin
         case (csr_ch.addr)
            arld_pkg::CSR_GRANTED_SESSION: granted_session_ff <= csr_ch.data;
            arld_pkg::CSR_STALL_LIMIT:     stall_limit_ff     <= csr_ch.data[15:0];
            arld_pkg::CSR_SAMPLE_FORMAT:   sample_format_ff   <= csr_ch.data[1:0];
            arld_pkg::CSR_OUT_CHANNELS:    out_channels_ff    <= csr_ch.data[3:0];
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         arld_pkg::ST_IDLE: begin
            if (req_fire && req_ch.req_type == arld_pkg::REQ_CONSUME) begin
               state_in = arld_pkg::ST_GATE;
            end
         end
         arld_pkg::ST_GATE: begin
            state_in = (n_ff == 7'd0) ? arld_pkg::ST_IDLE : arld_pkg::ST_DRAIN;
         end
         arld_pkg::ST_DRAIN: begin
            if (issue && last_frame) begin
               state_in = arld_pkg::ST_IDLE;
            end
         end
         default: state_in = arld_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready  = 1'b0;
      gate_cycle = 1'b0;
      issue      = 1'b0;
      case (state_ff)
         arld_pkg::ST_IDLE:  req_ready  = 1'b1;
         arld_pkg::ST_GATE:  gate_cycle = 1'b1;
         arld_pkg::ST_DRAIN: issue = (credit_ff < arld_pkg::FIFO_CW'(arld_pkg::FIFO_DEPTH));
         default: ;
      endcase
   end

   // grant, session and heartbeat check, plus lapped-reader fixup
   always_comb begin
      seen_grant_in     = seen_grant_ff;
      last_heartbeat_in = last_heartbeat_ff;
      stall_count_in    = stall_count_ff;
      stall_inc = (stall_count_ff < arld_pkg::STALL_MAX) ? stall_count_ff + 17'd1
                                                         : stall_count_ff;
      live = 1'b1;
      if (granted_session_ff == '0 || prod_session_ff != granted_session_ff) begin
         live = 1'b0;
      end else if (granted_session_ff != seen_grant_ff) begin
         // new grant opens a fresh stall window
         seen_grant_in     = granted_session_ff;
         last_heartbeat_in = prod_heartbeat_ff;
         stall_count_in    = '0;
      end else if (prod_heartbeat_ff == last_heartbeat_ff) begin
         stall_count_in = stall_inc;
         live = !(stall_inc > {1'b0, stall_limit_ff});
      end else begin
         last_heartbeat_in = prod_heartbeat_ff;
         stall_count_in    = '0;
      end

      avail   = write_index_ff - read_index_ff;
      lapped  = (avail > 32'(arld_pkg::RING_FRAMES));
      r_start = lapped ? write_index_ff - 32'(arld_pkg::RING_FRAMES) : read_index_ff;
      avail_c = lapped ? 32'(arld_pkg::RING_FRAMES) : avail;
   end

   always_comb begin
      write_index_in    = write_index_ff;
      read_index_in     = read_index_ff;
      prod_session_in   = prod_session_ff;
      prod_heartbeat_in = prod_heartbeat_ff;
      n_in              = n_ff;
      give_in           = give_ff;
      frame_in          = frame_ff;
      rd_ptr_in         = rd_ptr_ff;
      ram_we            = 1'b0;

      if (req_fire) begin
         case (req_ch.req_type)
            arld_pkg::REQ_PUSH: begin
               ram_we         = 1'b1;
               write_index_in = write_index_ff + 32'd1;
            end
            arld_pkg::REQ_STATUS: begin
               prod_session_in   = req_ch.session_id;
               prod_heartbeat_in = req_ch.heartbeat_value;
            end
            arld_pkg::REQ_CONSUME: begin
               n_in = (req_ch.frame_count > 7'(arld_pkg::PERIOD_MAX))
                    ? 7'(arld_pkg::PERIOD_MAX) : req_ch.frame_count;
               frame_in = '0;
            end
            default: ;
         endcase
      end

      if (gate_cycle) begin
         give_in = '0;
         if (live) begin
            give_in = (avail_c < {25'd0, n_ff}) ? avail_c[6:0] : n_ff;
            read_index_in = r_start + {25'd0, give_in};
         end
         rd_ptr_in = r_start[arld_pkg::RING_AW-1:0];
      end

      if (issue) begin
         frame_in  = frame_ff + 7'd1;
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end

      issue_meta.from_ring   = (frame_ff < give_ff);
      issue_meta.frame_index = frame_ff[5:0];
      issue_meta.last        = last_frame;

      credit_in = credit_ff;
      if (issue && !rsp_pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (rsp_pop && !issue) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      give_ff   <= give_in;
      frame_ff  <= frame_in;
      rd_ptr_ff <= rd_ptr_in;
      meta1_ff  <= issue_meta;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= arld_pkg::ST_IDLE;
         write_index_ff    <= '0;
         read_index_ff     <= '0;
         prod_session_ff   <= '0;
         prod_heartbeat_ff <= '0;
         seen_grant_ff     <= '0;
         last_heartbeat_ff <= '0;
         stall_count_ff    <= '0;
         credit_ff         <= '0;
         valid1_ff         <= 1'b0;
      end else begin
         state_ff          <= state_in;
         write_index_ff    <= write_index_in;
         read_index_ff     <= read_index_in;
         prod_session_ff   <= prod_session_in;
         prod_heartbeat_ff <= prod_heartbeat_in;
         credit_ff         <= credit_in;
         valid1_ff         <= issue;
         if (gate_cycle) begin
            seen_grant_ff     <= seen_grant_in;
            last_heartbeat_ff <= last_heartbeat_in;
            stall_count_ff    <= stall_count_in;
         end
      end
   end

   arld_ring_ram #(
      .WIDTH (arld_pkg::ENTRY_W),
      .DEPTH (arld_pkg::RING_FRAMES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (write_index_ff[arld_pkg::RING_AW-1:0]),
      .wr_data ({req_ch.right_sample, req_ch.left_sample}),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff),
      .rd_data (ram_q)
   );

   arld_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (valid1_ff),
      .in_meta       (meta1_ff),
      .in_entry      (ram_q),
      .sample_format (sample_format_ff),
      .mono          (mono),
      .out_valid     (sc_valid),
      .out_rsp       (sc_rsp)
   );

   arld_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (sc_valid),
      .push_data (sc_rsp),
      .pop_valid (rsp_ch.valid),
      .pop_ready (rsp_ch.ready),
      .pop_data  (q_rsp)
   );

   assign rsp_ch.ch0_word    = q_rsp.ch0_word;
   assign rsp_ch.ch1_word    = q_rsp.ch1_word;
   assign rsp_ch.frame_index = q_rsp.frame_index;
   assign rsp_ch.from_ring   = q_rsp.from_ring;
   assign rsp_ch.last        = q_rsp.last;

endmodule

`default_nettype wire

// ===== bench/tb_audio_ring_drain_with_liveness_top.sv =====
// self-checking bench for the audio ring drain: drives push, status, consume and no-op
// transfers and register writes, predicts every output frame and compares them in order
// depends on arld_pkg, the channel interfaces and audio_ring_drain_with_liveness_top
module tb_audio_ring_drain_with_liveness_top;
   timeunit 1ns;
   timeprecision 1ps;

   import arld_pkg::*;

   localparam int HANG_LIMIT  = 4000;
   localparam int DRAIN_PAUSE = 16;

   typedef struct packed {
      arld_req_code_type kind;
      logic [23:0]       left;
      logic [23:0]       right;
      logic [31:0]       session;
      logic [31:0]       heartbeat;
      logic [6:0]        count;
   } drain_req_type;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   arld_req_if req_ch ();
   arld_rsp_if rsp_ch ();
   arld_csr_if csr_ch ();

   audio_ring_drain_with_liveness_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // register shadow, reset values
   logic [31:0]  cfg_grant       = 32'd0;
   logic [15:0]  cfg_stall_limit = 16'd8;
   arld_fmt_type cfg_format      = FMT_INT16;
   logic [3:0]   cfg_channels    = 4'd2;

   // ring and liveness state of the block
   logic [47:0] ring_mem [RING_FRAMES];
   logic [31:0] wr_idx         = '0;
   logic [31:0] rd_idx         = '0;
   logic [31:0] prod_session   = '0;
   logic [31:0] prod_heartbeat = '0;
   logic [31:0] seen_grant     = '0;
   logic [31:0] last_heartbeat = '0;
   logic [16:0] stall_count    = '0;

   arld_rsp_type expected_frames [$];
   arld_rsp_type rsp_want;
   int           mismatches  = 0;
   int           idle_cycles = 0;
   int           burst_left  = 0;
   int           gap_len     = 0;
   logic [31:0]  hb_now      = '0;
   rx_mode_type  rx_mode     = RX_OPEN;
   int           rx_left     = 0;

   // trunc(num * K / 2^shift) toward zero
   function automatic logic [31:0] scale_word(logic signed [63:0] num, int shift);
      logic [63:0] k;
      logic [63:0] mag;
      logic [63:0] q;
      case (cfg_format)
         FMT_INT16: k = 64'd32767;
         FMT_INT24: k = 64'd8388607;
         FMT_INT32: k = 64'd2147483647;
         default:   return 32'd0;
      endcase
      mag = num[63] ? -num : num;
      q = (mag * k) >> shift;
      if (num[63])
         q = -q;
      return q[31:0];
   endfunction

   function automatic arld_rsp_type ring_frame(int unsigned f, int unsigned n, bit from_ring,
                                               logic [47:0] slot);
      arld_rsp_type     fr;
      logic signed [63:0] lft;
      logic signed [63:0] rgt;
      lft = $signed(slot[23:0]);
      rgt = $signed(slot[47:24]);
      fr = '0;
      if (from_ring) begin
         if (cfg_channels == 4'd1) begin
            fr.ch0_word = scale_word(lft + rgt, 24);
         end else begin
            fr.ch0_word = scale_word(lft, 23);
            fr.ch1_word = scale_word(rgt, 23);
         end
      end
      fr.frame_index = 6'(f);
      fr.from_ring   = from_ring;
      fr.last        = (f + 1 == n);
      return fr;
   endfunction

   // update the state for one accepted transfer and queue the frames it produces
   task automatic apply_request(input drain_req_type it);
      int unsigned n;
      int unsigned give;
      int unsigned avail;
      logic [31:0] rd;
      logic [31:0] slot_addr;
      bit          live;
      case (it.kind)
         REQ_PUSH: begin
            ring_mem[wr_idx[RING_AW-1:0]] = {it.right, it.left};
            wr_idx = wr_idx + 32'd1;
         end
         REQ_STATUS: begin
            prod_session   = it.session;
            prod_heartbeat = it.heartbeat;
         end
         REQ_CONSUME: begin
            n = (it.count > PERIOD_MAX) ? PERIOD_MAX : it.count;
            live = 1'b1;
            if (cfg_grant == 0 || prod_session != cfg_grant) begin
               live = 1'b0;
            end else if (cfg_grant != seen_grant) begin
               // new grant opens a fresh stall window
               seen_grant     = cfg_grant;
               last_heartbeat = prod_heartbeat;
               stall_count    = '0;
            end else if (prod_heartbeat == last_heartbeat) begin
               if (stall_count != STALL_MAX)
                  stall_count = stall_count + 17'd1;
               if (stall_count > cfg_stall_limit)
                  live = 1'b0;
            end else begin
               last_heartbeat = prod_heartbeat;
               stall_count    = '0;
            end
            give = 0;
            rd = rd_idx;
            if (live) begin
               avail = wr_idx - rd;
               // writer lapped the reader: restart at the oldest frame still held
               if (avail > RING_FRAMES) begin
                  rd    = wr_idx - RING_FRAMES;
                  avail = RING_FRAMES;
               end
               give = (avail < n) ? avail : n;
               rd_idx = rd + give;
            end
            for (int unsigned f = 0; f < n; f++) begin
               slot_addr = rd + f;
               expected_frames.push_back(ring_frame(f, n, f < give,
                                                    ring_mem[slot_addr[RING_AW-1:0]]));
            end
         end
         default: ;
      endcase
   endtask

   function automatic drain_req_type noise_req();
      drain_req_type it;
      it.kind      = arld_req_code_type'($urandom_range(0, 3));
      it.left      = 24'($urandom);
      it.right     = 24'($urandom);
      it.session   = $urandom;
      it.heartbeat = $urandom;
      it.count     = 7'($urandom);
      return it;
   endfunction

   function automatic drain_req_type mk_push(logic [23:0] l, logic [23:0] r);
      drain_req_type it;
      it = noise_req();
      it.kind  = REQ_PUSH;
      it.left  = l;
      it.right = r;
      return it;
   endfunction

   function automatic drain_req_type mk_status(logic [31:0] s, logic [31:0] hb);
      drain_req_type it;
      it = noise_req();
      it.kind      = REQ_STATUS;
      it.session   = s;
      it.heartbeat = hb;
      return it;
   endfunction

   function automatic drain_req_type mk_consume(logic [6:0] n);
      drain_req_type it;
      it = noise_req();
      it.kind  = REQ_CONSUME;
      it.count = n;
      return it;
   endfunction

   // one request transfer; the sender runs in bursts with random gaps in between
   task automatic send_req(input drain_req_type it);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap_len    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      if (gap_len > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap_len) @(negedge clock);
         gap_len = 0;
      end
      req_ch.req_type        = it.kind;
      req_ch.left_sample     = it.left;
      req_ch.right_sample    = it.right;
      req_ch.session_id      = it.session;
      req_ch.heartbeat_value = it.heartbeat;
      req_ch.frame_count     = it.count;
      req_ch.valid           = 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      apply_request(it);
   endtask

   // drop valid, wait for every frame, then let the pipeline go quiet
   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (DRAIN_PAUSE) @(posedge clock);
   endtask

   task automatic write_reg(input arld_csr_code_type idx, input logic [31:0] value);
      settle();
      @(negedge clock);
      csr_ch.addr  = idx;
      csr_ch.data  = value;
      csr_ch.valid = 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      case (idx)
         CSR_GRANTED_SESSION: cfg_grant       = value;
         CSR_STALL_LIMIT:     cfg_stall_limit = value[15:0];
         CSR_SAMPLE_FORMAT:   cfg_format      = arld_fmt_type'(value[1:0]);
         CSR_OUT_CHANNELS:    cfg_channels    = value[3:0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic test_no_grant();
      drain_req_type it;
      send_req(mk_consume(7'd5));
      it = noise_req();
      it.kind      = REQ_NONE;
      it.left      = '1;
      it.right     = '1;
      it.session   = '1;
      it.heartbeat = '1;
      it.count     = '1;
      send_req(it);
      send_req(mk_consume(7'd0));
   endtask

   task automatic test_format_scaling();
      write_reg(CSR_GRANTED_SESSION, 32'hFFFF_FFFF);
      send_req(mk_status(32'hFFFF_FFFF, 32'd0));
      send_req(mk_push(24'h7FFFFF, 24'h800000));
      send_req(mk_push(24'h800000, 24'h7FFFFF));
      send_req(mk_push(24'h000000, 24'hFFFFFF));
      send_req(mk_push(24'h400000, 24'hC00001));
      send_req(mk_consume(7'd1));
      write_reg(CSR_SAMPLE_FORMAT, 32'(FMT_INT24));
      send_req(mk_consume(7'd1));
      write_reg(CSR_SAMPLE_FORMAT, 32'(FMT_INT32));
      send_req(mk_consume(7'd1));
      // undefined format still reads the ring but gives zero words
      write_reg(CSR_SAMPLE_FORMAT, 32'(FMT_NONE));
      send_req(mk_consume(7'd1));
   endtask

   task automatic test_mono_and_channels();
      write_reg(CSR_SAMPLE_FORMAT, 32'(FMT_INT32));
      write_reg(CSR_OUT_CHANNELS, 32'd1);
      send_req(mk_push(24'h7FFFFF, 24'h7FFFFF));
      send_req(mk_push(24'h800000, 24'h800000));
      // oversized request saturates, runs dry after two frames
      send_req(mk_consume(7'd127));
      write_reg(CSR_OUT_CHANNELS, 32'd0);
      send_req(mk_push(24'h123456, 24'hFEDCBA));
      send_req(mk_consume(7'd1));
   endtask

   task automatic test_liveness_gate();
      write_reg(CSR_STALL_LIMIT, 32'd0);
      send_req(mk_consume(7'd2));
      send_req(mk_status(32'hFFFF_FFFF, 32'd1));
      send_req(mk_push(24'h654321, 24'h0ABCDE));
      send_req(mk_consume(7'd1));
      send_req(mk_status(32'd1, 32'd2));
      send_req(mk_consume(7'd2));
      write_reg(CSR_OUT_CHANNELS, 32'd8);
      write_reg(CSR_STALL_LIMIT, 32'h0000_FFFF);
      write_reg(CSR_GRANTED_SESSION, 32'd1);
      send_req(mk_consume(7'd1));
   endtask

   task automatic test_random_traffic();
      logic [31:0] sess;
      logic [31:0] noise;
      logic [15:0] lim;
      logic [3:0]  chans;
      logic [6:0]  n;
      int          done;
      int          pick;
      for (int ph = 0; ph < 7; ph++) begin
         sess  = (ph == 4) ? 32'd0 : $urandom;
         lim   = (ph == 0) ? 16'd0 : (ph == 1) ? 16'hFFFF : 16'($urandom_range(0, 4));
         chans = (ph == 0) ? 4'd1 : (ph == 1) ? 4'd15 : 4'($urandom_range(0, 15));
         noise = $urandom;
         write_reg(CSR_GRANTED_SESSION, sess);
         write_reg(CSR_STALL_LIMIT, {noise[31:16], lim});
         write_reg(CSR_SAMPLE_FORMAT, {noise[31:2], 2'(ph)});
         write_reg(CSR_OUT_CHANNELS, {noise[31:4], chans});
         hb_now = $urandom;
         send_req(mk_status((sess == 0) ? $urandom : sess, hb_now));
         done = 0;
         while (done < 28) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               send_req(mk_push(24'($urandom), 24'($urandom)));
               done++;
            end else if (pick < 55) begin
               // mostly the granted producer, sometimes a frozen heartbeat or a stranger
               if ($urandom_range(0, 2) != 0)
                  hb_now = $urandom;
               send_req(mk_status(($urandom_range(0, 9) == 0) ? $urandom : sess, hb_now));
               done++;
            end else if (pick < 95) begin
               case ($urandom_range(0, 19))
                  0:       n = 7'd0;
                  1:       n = 7'd64;
                  2:       n = 7'($urandom_range(65, 127));
                  default: n = 7'($urandom_range(1, 16));
               endcase
               send_req(mk_consume(n));
               done++;
            end else begin
               send_req(noise_req());
            end
         end
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: unexpected frame expected none actual ch0 %h ch1 %h idx %0d",
                     $time, rsp_ch.ch0_word, rsp_ch.ch1_word, rsp_ch.frame_index);
            mismatches++;
         end else begin
            rsp_want = expected_frames.pop_front();
            check_field("ch0_word", rsp_want.ch0_word, rsp_ch.ch0_word);
            check_field("ch1_word", rsp_want.ch1_word, rsp_ch.ch1_word);
            check_field("frame_index", 32'(rsp_want.frame_index), 32'(rsp_ch.frame_index));
            check_field("from_ring", 32'(rsp_want.from_ring), 32'(rsp_ch.from_ring));
            check_field("last", 32'(rsp_want.last), 32'(rsp_ch.last));
         end
      end
   end

   // receiver stalls on its own pattern: open, light and heavy stretches
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         rx_left = $urandom_range(16, 160);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         RX_OPEN:  rsp_ch.ready = 1'b1;
         RX_LIGHT: rsp_ch.ready = ($urandom_range(0, 3) != 0);
         default:  rsp_ch.ready = ($urandom_range(0, 5) == 0);
      endcase
   end

   // hang detection: any transfer on any channel restarts the count
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= HANG_LIMIT) begin
         $display("tb_audio_ring_drain_with_liveness_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_ch.valid           = 1'b0;
      req_ch.req_type        = REQ_PUSH;
      req_ch.left_sample     = '0;
      req_ch.right_sample    = '0;
      req_ch.session_id      = '0;
      req_ch.heartbeat_value = '0;
      req_ch.frame_count     = '0;
      csr_ch.valid           = 1'b0;
      csr_ch.addr            = CSR_GRANTED_SESSION;
      csr_ch.data            = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_no_grant();
      test_format_scaling();
      test_mono_and_channels();
      test_liveness_gate();
      test_random_traffic();
      settle();

      if (mismatches == 0)
         $display("tb_audio_ring_drain_with_liveness_top OK");
      else
         $display("tb_audio_ring_drain_with_liveness_top NOT OK");
      $finish;
   end

endmodule
